>>> hw/rtl/utf8_code_point_encoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 encoder assertion macros
// Clocked assertion shorthands; expect clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_ENCODER_MACROS_SVH
`define UTF8_CODE_POINT_ENCODER_MACROS_SVH

// same-cycle implication
`define UTF8E_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define UTF8E_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8e_pkg.sv
// ----------------------------------------------------------------------------
// utf8e_pkg
// Shared types and constants of the UTF-8 code point encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8e_pkg;

  localparam int unsigned MaxBytes = 6;

  localparam logic [7:0] Lead2   = 8'hC0;
  localparam logic [7:0] Lead3   = 8'hE0;
  localparam logic [7:0] Lead4   = 8'hF0;
  localparam logic [7:0] Lead5   = 8'hF8;
  localparam logic [7:0] Lead6   = 8'hFC;
  localparam logic [7:0] LeadTop = 8'hFE;
  localparam logic [7:0] Cont    = 8'h80;

  localparam logic [31:0] ErrLo  = 32'h0000_EF80;
  localparam logic [31:0] ErrHi  = 32'h0000_EFFF;
  localparam logic [31:0] SuppLo = 32'h0001_0000;
  localparam logic [31:0] SuppHi = 32'h0010_FFFF;
  localparam logic [15:0] HiSurr = 16'hD800;
  localparam logic [15:0] LoSurr = 16'hDC00;

  typedef enum logic [1:0] {
    REG_ALLOW_ERROR_ESCAPES = 2'd0,
    REG_ALLOW_SURROGATES    = 2'd1,
    REG_ALLOW_ENCODED_ZERO  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic allow_error_escapes;
    logic allow_surrogates;
    logic allow_encoded_zero;
  } cfg_t;

  // byte 0 goes out first; len is 1..6
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               len;
  } run_t;

endpackage

`default_nettype wire

>>> hw/rtl/utf8_code_point_encoder.sv
// ----------------------------------------------------------------------------
// utf8_code_point_encoder
// Encodes 32-bit code points as UTF-8 runs; error-escape, CESU-8, C0 80 modes.
// ----------------------------------------------------------------------------
// A code point is taken into an input register, encoded in one pass into a
// run of 1 to 6 bytes, and the run is loaded into an output shift register
// that hands out one byte per output transaction, with out_last_byte on the
// final byte. The output byte channel sets the rate: with out_ready high,
// single-byte characters flow at one per cycle, the next code point taken
// while a run drains. The first byte is offered once its run is loaded into
// the output shift register, after any earlier run; it leaves at the next
// edge with out_ready high. The user must write the three mode registers
// through the cfg port only while the block idles; nothing here enforces it.
`default_nettype none

module utf8_code_point_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_code_point,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  utf8e_pkg::cfg_t cfg_r;
  utf8e_pkg::cfg_t cfg_nxt;
  utf8e_pkg::run_t run;
  logic            run_valid;
  logic            run_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        utf8e_pkg::REG_ALLOW_ERROR_ESCAPES: cfg_nxt.allow_error_escapes = cfg_wdata;
        utf8e_pkg::REG_ALLOW_SURROGATES:    cfg_nxt.allow_surrogates    = cfg_wdata;
        utf8e_pkg::REG_ALLOW_ENCODED_ZERO:  cfg_nxt.allow_encoded_zero  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  utf8e_encode u_encode (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_point (in_code_point),
    .run_valid     (run_valid),
    .run_ready     (run_ready),
    .run           (run)
  );

  utf8e_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .run_valid     (run_valid),
    .run_ready     (run_ready),
    .run           (run),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire

>>> hw/rtl/utf8e_encode.sv
// ----------------------------------------------------------------------------
// utf8e_encode
// Input register and byte-run encoding of one code point.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8e_encode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire utf8e_pkg::cfg_t cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     in_code_point,
  output logic                 run_valid,
  input  wire logic            run_ready,
  output utf8e_pkg::run_t      run
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] cp_r;

  function automatic logic [7:0] cont6(logic [5:0] bits);
    return utf8e_pkg::Cont | {2'b00, bits};
  endfunction

  function automatic utf8e_pkg::run_t multi(logic [31:0] c);
    utf8e_pkg::run_t r;
    r.bytes = '0;
    if (c <= 32'h0000_07FF) begin
      r.bytes[0] = utf8e_pkg::Lead2 | {3'b000, c[10:6]};
      r.bytes[1] = cont6(c[5:0]);
      r.len      = 3'd2;
    end else if (c <= 32'h0000_FFFF) begin
      r.bytes[0] = utf8e_pkg::Lead3 | {4'b0000, c[15:12]};
      r.bytes[1] = cont6(c[11:6]);
      r.bytes[2] = cont6(c[5:0]);
      r.len      = 3'd3;
    end else if (c <= 32'h001F_FFFF) begin
      r.bytes[0] = utf8e_pkg::Lead4 | {5'b00000, c[20:18]};
      r.bytes[1] = cont6(c[17:12]);
      r.bytes[2] = cont6(c[11:6]);
      r.bytes[3] = cont6(c[5:0]);
      r.len      = 3'd4;
    end else if (c <= 32'h03FF_FFFF) begin
      r.bytes[0] = utf8e_pkg::Lead5 | {6'b000000, c[25:24]};
      r.bytes[1] = cont6(c[23:18]);
      r.bytes[2] = cont6(c[17:12]);
      r.bytes[3] = cont6(c[11:6]);
      r.bytes[4] = cont6(c[5:0]);
      r.len      = 3'd5;
    end else begin
      if (c <= 32'h7FFF_FFFF) begin
        r.bytes[0] = utf8e_pkg::Lead6 | {7'b0000000, c[30]};
      end else begin
        r.bytes[0] = utf8e_pkg::LeadTop;
      end
      r.bytes[1] = cont6(c[29:24]);
      r.bytes[2] = cont6(c[23:18]);
      r.bytes[3] = cont6(c[17:12]);
      r.bytes[4] = cont6(c[11:6]);
      r.bytes[5] = cont6(c[5:0]);
      r.len      = 3'd6;
    end
    return r;
  endfunction

  function automatic utf8e_pkg::run_t encode_cp(logic [31:0] c, utf8e_pkg::cfg_t f);
    utf8e_pkg::run_t r;
    utf8e_pkg::run_t hi_run;
    utf8e_pkg::run_t lo_run;
    logic [20:0]     dd;
    logic [15:0]     hs;
    logic [15:0]     ls;
    dd     = c[20:0] - utf8e_pkg::SuppLo[20:0];
    hs     = utf8e_pkg::HiSurr | {6'b000000, dd[19:10]};
    ls     = utf8e_pkg::LoSurr | {6'b000000, dd[9:0]};
    hi_run = multi({16'h0000, hs});
    lo_run = multi({16'h0000, ls});
    r.bytes = '0;
    r.len   = 3'd1;
    if (f.allow_error_escapes && c >= utf8e_pkg::ErrLo && c <= utf8e_pkg::ErrHi) begin
      r.bytes[0] = c[7:0];
    end else if (f.allow_surrogates && c >= utf8e_pkg::SuppLo &&
                 c <= utf8e_pkg::SuppHi) begin
      r.bytes[2:0] = hi_run.bytes[2:0];
      r.bytes[5:3] = lo_run.bytes[2:0];
      r.len        = 3'd6;
    end else if ((f.allow_encoded_zero && c == 32'h0) || c >= 32'h0000_0080) begin
      r = multi(c);
    end else begin
      r.bytes[0] = c[7:0];
    end
    return r;
  endfunction

  assign in_ready  = !valid_r || run_ready;
  assign run_valid = valid_r;
  assign run       = encode_cp(cp_r, cfg);

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (run_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cp_r <= in_code_point;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/utf8e_serializer.sv
// ----------------------------------------------------------------------------
// utf8e_serializer
// Holds one encoded byte run and shifts it out one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_code_point_encoder_macros.svh"

module utf8e_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            run_valid,
  output logic                 run_ready,
  input  wire utf8e_pkg::run_t run,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_byte
);

  logic                                  valid_r;
  logic                                  valid_nxt;
  logic [2:0]                            rem_r;
  logic [2:0]                            rem_nxt;
  logic [utf8e_pkg::MaxBytes-1:0][7:0]   bytes_r;
  logic [utf8e_pkg::MaxBytes-1:0][7:0]   bytes_nxt;
  logic                                  take;
  logic                                  load;

  assign out_valid     = valid_r;
  assign out_byte      = bytes_r[0];
  assign out_last_byte = (rem_r == 3'd1);
  assign take          = valid_r && out_ready;
  assign run_ready     = !valid_r || (out_ready && out_last_byte);
  assign load          = run_valid && run_ready;

  always_comb begin
    valid_nxt = valid_r;
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    if (load) begin
      valid_nxt = 1'b1;
      rem_nxt   = run.len;
      bytes_nxt = run.bytes;
    end else if (take) begin
      if (out_last_byte) begin
        valid_nxt = 1'b0;
      end else begin
        rem_nxt   = rem_r - 3'd1;
        bytes_nxt = {8'h00, bytes_r[utf8e_pkg::MaxBytes-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  `UTF8E_ASSERT_IMPL(a_rem_range, valid_r, rem_r != 3'd0 && rem_r <= 3'd6, "run length out of range")
  `UTF8E_ASSERT_NEXT(a_run_continues, take && !out_last_byte, valid_r && rem_r == $past(rem_r) - 3'd1, "run cut short")
  `UTF8E_ASSERT_NEXT(a_run_ends, take && out_last_byte && !run_valid, !valid_r, "byte after end of run")

endmodule

`default_nettype wire
